>>> hdl/nac_pkg.sv
// Package for the normalized autocorrelation unit.
// Widths and sizes shared by the top level and the testbench; no dependencies.
package nac_pkg;
  localparam int MaxSamples = 1024;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = AddrW + 1;
  localparam int SmpW       = 16;
  localparam int SumW       = SmpW + AddrW + 1;
  localparam int DevW       = SumW + 1;
  localparam int ProdW      = 2 * DevW;
  localparam int AccW       = ProdW + CntW + 1;
  localparam int LagW       = 6;
  localparam int CoefW      = 16;
  localparam int QuoW       = 15;
  localparam int StepW      = 4;
  localparam int DivSteps   = 15;
  localparam logic [CoefW-1:0] QOne = 16'd16384;
  localparam logic [LagW-1:0] LagLimitReset = 6'd16;
endpackage

>>> hdl/nac_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module nac_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

>>> hdl/normalized_autocorrelation_unit.sv
// Normalized autocorrelation unit: top level.
// Uses nac_pkg and nac_ram (sample store).
//
// channel  dir  handshake             payload
// in       in   in_valid_i/in_stall_o sample_i, block_end_i
// out      out  out_valid_o/out_stall_i lag_index_o, coefficient_o, final_lag_o, dropped_o
// cfg      in   APB psel/penable      lag_limit at byte address 0
//
// Samples load one beat per cycle while in_stall_o is low. After the block end each
// lag L walks the store once through a 4-stage read/deviation/multiply/accumulate pipe;
// the pipe then drains, a restoring division runs, and the beat is held until taken.
// The input is stalled from block end until the last coefficient is taken.
// Reset clears counters and control; the store holds no reset.
module normalized_autocorrelation_unit
  import nac_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SmpW-1:0]  sample_i,
  input  logic                    block_end_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [LagW-1:0]         lag_index_o,
  output logic signed [CoefW-1:0] coefficient_o,
  output logic                    final_lag_o,
  output logic                    dropped_o
);
  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StAcc   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [LagW-1:0]        lag_limit_q;
  logic [CntW-1:0]        count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   ovf_q, ovf_d;
  logic [LagW-1:0]        m_q, m_d, lag_q, lag_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   v1_q, v2_q, v3_q;
  logic signed [DevW-1:0] da_q, db_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0]        var_q, var_d, rem_q, rem_d;
  logic                   neg_q, neg_d;
  logic [QuoW-1:0]        quo_q, quo_d;
  logic [StepW-1:0]       step_q, step_d;
  logic signed [CoefW-1:0] coef_q, coef_d;

  logic                   in_acc, out_acc, cfg_wr, store_ok, issue;
  logic [CntW-1:0]        n_new, last_idx, addr_b;
  logic signed [SmpW-1:0] ra, rb;
  logic signed [DevW-1:0] sum_ext, n_ext, ra_ext, rb_ext;
  logic [AccW-1:0]        r_shift, acc_abs;
  logic [CoefW-1:0]       qclip;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : {{(32-LagW){1'b0}}, lag_limit_q};

  assign in_stall_o = (state_q != StLoad);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign store_ok   = (count_q < CntW'(MaxSamples));
  assign n_new      = store_ok ? count_q + 1'b1 : count_q;
  assign issue      = (state_q == StAcc);
  assign last_idx   = count_q - 1'b1 - CntW'(lag_q);
  assign addr_b     = idx_q + CntW'(lag_q);

  nac_ram #(.Width(SmpW), .Depth(MaxSamples)) u_store (
    .clk_i     (clk_i),
    .we_i      (in_acc && store_ok),
    .waddr_i   (count_q[AddrW-1:0]),
    .wdata_i   (sample_i),
    .raddr_a_i (idx_q[AddrW-1:0]),
    .raddr_b_i (addr_b[AddrW-1:0]),
    .rdata_a_o (ra),
    .rdata_b_o (rb)
  );

  assign sum_ext = {{(DevW-SumW){sum_q[SumW-1]}}, sum_q};
  assign n_ext   = {{(DevW-CntW){1'b0}}, count_q};
  assign ra_ext  = {{(DevW-SmpW){ra[SmpW-1]}}, ra};
  assign rb_ext  = {{(DevW-SmpW){rb[SmpW-1]}}, rb};

  always_ff @(posedge clk_i) begin
    da_q   <= n_ext * ra_ext - sum_ext;
    db_q   <= n_ext * rb_ext - sum_ext;
    prod_q <= da_q * db_q;
  end

  assign r_shift = (step_q == '0) ? rem_q : {rem_q[AccW-2:0], 1'b0};
  assign acc_abs = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign qclip   = ({1'b0, quo_q} > QOne) ? QOne : {1'b0, quo_q};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    m_d     = m_q;
    lag_d   = lag_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    var_d   = var_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    step_d  = step_q;
    coef_d  = coef_q;
    if (v3_q) begin
      acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (store_ok) begin
            count_d = n_new;
            sum_d   = sum_q + SumW'(sample_i);
          end else begin
            ovf_d = 1'b1;
          end
          if (block_end_i) begin
            m_d     = (CntW'(lag_limit_q) > n_new - 1'b1) ? LagW'(n_new - 1'b1)
                                                        : lag_limit_q;
            lag_d   = '0;
            idx_d   = '0;
            acc_d   = '0;
            state_d = StAcc;
          end
        end
      end
      StAcc: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == last_idx) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!v1_q && !v2_q && !v3_q) begin
          if (lag_q == '0) begin
            var_d = AccW'(acc_q);
          end
          neg_d   = acc_q[AccW-1];
          rem_d   = acc_abs;
          quo_d   = '0;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (r_shift >= var_q) begin
          rem_d = r_shift - var_q;
          quo_d = {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_d = r_shift;
          quo_d = {quo_q[QuoW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps)) begin
          quo_d   = quo_q;
          rem_d   = rem_q;
          coef_d  = (var_q == '0) ? '0 : (neg_q ? -$signed(qclip) : $signed(qclip));
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (lag_q == m_q) begin
            count_d = '0;
            sum_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            lag_d   = lag_q + 1'b1;
            idx_d   = '0;
            acc_d   = '0;
            state_d = StAcc;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      lag_limit_q <= LagLimitReset;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      m_q         <= '0;
      lag_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        lag_limit_q <= pwdata[LagW-1:0];
      end
      count_q <= count_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      m_q     <= m_d;
      lag_q   <= lag_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    var_q  <= var_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
    coef_q <= coef_d;
  end

  assign lag_index_o   = lag_q;
  assign coefficient_o = coef_q;
  assign final_lag_o   = (lag_q == m_q);
  assign dropped_o     = ovf_q;

  a_div_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> !v1_q && !v2_q && !v3_q)
    else $error("division started with products in flight");
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coefficient_o <= $signed(QOne) && coefficient_o >= -$signed(QOne))
    else $error("coefficient out of range");
  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StLoad |-> lag_q <= m_q && CntW'(m_q) < count_q)
    else $error("lag beyond block");
  a_lag0_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lag_q == '0 && var_q != '0 |-> coefficient_o == $signed(QOne))
    else $error("lag zero not unity");
endmodule

>>> tb/tb_normalized_autocorrelation_unit.sv
// Testbench for normalized_autocorrelation_unit: directed and random sample blocks,
// lag_limit writes over APB, checked beat by beat against a built-in predictor.
// Depends on nac_pkg and the unit's RTL only.
module tb_normalized_autocorrelation_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import nac_pkg::*;

  typedef struct {
    logic [LagW-1:0]         lag;
    logic signed [CoefW-1:0] coef;
    logic                    fin;
    logic                    drop;
  } coef_beat_t;

  class acorr_scoreboard;
    logic signed [SmpW-1:0] samples [MaxSamples];
    int unsigned            count;
    longint                 sum;
    bit                     overflow;
    logic [LagW-1:0]        lag_limit;
    coef_beat_t             pending [$];
    int                     errors;

    function void clear();
      count = 0;
      sum = 0;
      overflow = 0;
      lag_limit = LagLimitReset;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function void note_sample(logic signed [SmpW-1:0] y, logic last);
      longint dev [MaxSamples];
      logic signed [127:0] var_acc, c_acc, num;
      int unsigned m, q;
      coef_beat_t b;
      if (count < MaxSamples) begin
        samples[count] = y;
        count++;
        sum += y;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      m = lag_limit;
      if (count == 0) m = 0;
      else if (m > count - 1) m = count - 1;
      var_acc = 0;
      for (int i = 0; i < count; i++) begin
        dev[i] = longint'(count) * longint'(samples[i]) - sum;
        var_acc += 128'(dev[i] * dev[i]);
      end
      for (int l = 0; l <= m; l++) begin
        q = 0;
        c_acc = 0;
        if (var_acc != 0) begin
          for (int i = 0; i + l < count; i++) c_acc += 128'(dev[i] * dev[i + l]);
          num = (c_acc < 0) ? -c_acc : c_acc;
          q = int'((num * 16384) / var_acc);
          if (q > 16384) q = 16384;
        end
        b.lag = LagW'(l);
        b.coef = (c_acc < 0) ? -CoefW'(q) : CoefW'(q);
        b.fin = (l == m);
        b.drop = overflow;
        pending = {pending, b};
      end
      count = 0;
      sum = 0;
      overflow = 0;
    endfunction

    task check_beat(logic [LagW-1:0] lag, logic signed [CoefW-1:0] coef, logic fin,
                    logic drop);
      coef_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat lag %0d coef %0d", lag, coef));
        return;
      end
      e = pending.pop_front();
      if (lag !== e.lag || coef !== e.coef || fin !== e.fin || drop !== e.drop)
        report($sformatf("lag %0d/%0d coef %0d/%0d final %b/%b dropped %b/%b (got/exp)",
                         lag, e.lag, coef, e.coef, fin, e.fin, drop, e.drop));
    endtask
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, block_end;
  logic signed [SmpW-1:0] sample;
  logic out_valid, out_stall, final_lag, dropped;
  logic [LagW-1:0] lag_index;
  logic signed [CoefW-1:0] coefficient;

  normalized_autocorrelation_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_i(sample),
    .block_end_i(block_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .lag_index_o(lag_index),
    .coefficient_o(coefficient), .final_lag_o(final_lag), .dropped_o(dropped)
  );

  acorr_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  localparam int QuietLimit = 40000;

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(lag_index, coefficient, final_lag, dropped);
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task send_sample(logic signed [SmpW-1:0] y, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    sample <= y;
    block_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_sample(y, last);
    @(negedge clk);
  endtask

  task wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task write_lag_limit(logic [2:0] addr, logic [31:0] value);
    wait_drained();
    psel <= 1;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == 0) sb.lag_limit = value[LagW-1:0];
    @(negedge clk);
  endtask

  task send_block(int n, int kind);
    logic signed [SmpW-1:0] y;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: y = SmpW'($urandom);
        1: y = 16'sh1234;
        2: y = (i % 2) ? 16'sh7fff : 16'sh8000;
        default: y = SmpW'(int'($urandom_range(40)) - 20);
      endcase
      send_sample(y, i == n - 1);
    end
  endtask

  initial begin
    sb.clear();
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; sample = 0; block_end = 0; out_stall = 0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_block(1, 0);
    send_block(4, 1);
    send_block(5, 2);
    send_block(3, 0);
    write_lag_limit(0, 32'hffff_ffc0);
    send_block(3, 0);
    write_lag_limit(0, 32'h0000_003f);
    send_block(6, 3);
    write_lag_limit(3'd4, 32'h1);
    write_lag_limit(0, 16);

    for (int ph = 0; ph < 4; ph++) begin
      int items;
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 60) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 60) : 0;
      write_lag_limit(0, (ph == 0) ? 63 : $urandom_range(63));
      items = 0;
      while (items < 48) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        send_block(n, ($urandom_range(7) == 0) ? 3 : 0);
        items += n;
        if ($urandom_range(3) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> filelist.f
hdl/nac_pkg.sv
hdl/nac_ram.sv
hdl/normalized_autocorrelation_unit.sv
tb/tb_normalized_autocorrelation_unit.sv
